// ----- rtl/dtm_pkg.sv -----
// Shared types and constants for the double to minifloat converter.
package dtm_pkg;

	localparam int unsigned SrcW = 64;
	localparam int unsigned OutW = 64;
	localparam int unsigned EwW = 4;
	localparam int unsigned FwW = 6;
	localparam int unsigned AddrW = 3;

	// Register addresses.
	localparam logic [AddrW-1:0] ADDR_EXP_WIDTH = 3'd0;
	localparam logic [AddrW-1:0] ADDR_FRAC_WIDTH = 3'd4;

	localparam logic [EwW-1:0] EW_RESET = 4'd8;
	localparam logic [FwW-1:0] FW_RESET = 6'd23;
	localparam logic [EwW-1:0] EW_MIN = 4'd2;
	localparam logic [EwW-1:0] EW_MAX = 4'd11;
	localparam logic [FwW-1:0] FW_MIN = 6'd1;
	localparam logic [FwW-1:0] FW_MAX = 6'd52;

	// Clamped format, passed from the register block to the datapath.
	typedef struct packed {
		logic [EwW-1:0] ew;
		logic [FwW-1:0] fw;
	} fmt_t;

	typedef struct packed {
		logic [OutW-1:0] packed_value;
		logic inexact;
		logic overflowed;
	} result_t;

endpackage

// ----- rtl/dtm_if.sv -----
// Valid/ready channel interfaces for source and result items.
interface dtm_src_if;
	logic valid;
	logic ready;
	logic [dtm_pkg::SrcW-1:0] source_bits;
	modport source (output valid, output source_bits, input ready);
	modport sink (input valid, input source_bits, output ready);
endinterface

interface dtm_res_if;
	logic valid;
	logic ready;
	logic [dtm_pkg::OutW-1:0] packed_value;
	logic inexact;
	logic overflowed;
	modport source (output valid, output packed_value, output inexact, output overflowed,
		input ready);
	modport sink (input valid, input packed_value, input inexact, input overflowed,
		output ready);
endinterface

// ----- rtl/dtm_regs.sv -----
// APB configuration registers with range clamping.
module dtm_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [dtm_pkg::AddrW-1:0]  paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output dtm_pkg::fmt_t              fmt
);
	logic [dtm_pkg::EwW-1:0] ew_q;
	logic [dtm_pkg::FwW-1:0] fw_q;
	logic wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	// Write registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ew_q <= dtm_pkg::EW_RESET;
			fw_q <= dtm_pkg::FW_RESET;
		end else if (wr) begin
			case (paddr)
				dtm_pkg::ADDR_EXP_WIDTH: ew_q <= pwdata[dtm_pkg::EwW-1:0];
				dtm_pkg::ADDR_FRAC_WIDTH: fw_q <= pwdata[dtm_pkg::FwW-1:0];
				default: ;
			endcase
		end
	end

	// Read back.
	always_comb begin
		case (paddr)
			dtm_pkg::ADDR_EXP_WIDTH: prdata = {28'd0, ew_q};
			dtm_pkg::ADDR_FRAC_WIDTH: prdata = {26'd0, fw_q};
			default: prdata = '0;
		endcase
	end

	// Clamp into the supported range.
	always_comb begin
		fmt.ew = (ew_q < dtm_pkg::EW_MIN) ? dtm_pkg::EW_MIN :
			(ew_q > dtm_pkg::EW_MAX) ? dtm_pkg::EW_MAX : ew_q;
		fmt.fw = (fw_q < dtm_pkg::FW_MIN) ? dtm_pkg::FW_MIN :
			(fw_q > dtm_pkg::FW_MAX) ? dtm_pkg::FW_MAX : fw_q;
	end
endmodule

// ----- rtl/dtm_convert.sv -----
// Combinational conversion of one double to the configured format.
module dtm_convert (
	input  logic [dtm_pkg::SrcW-1:0] src,
	input  dtm_pkg::fmt_t            fmt,
	output dtm_pkg::result_t         res
);
	logic        sign;
	logic [10:0] bexp;
	logic [51:0] frac;
	logic [52:0] m;
	logic [5:0]  p;
	logic signed [13:0] e, x, bias, emin, shift, base;
	logic [63:0] exp_ones, inf_mag, mag, q, rest_mask;
	logic [63:0] mext;
	logic        normal, g, rest, inx, ovf;
	logic [6:0]  fwe;

	always_comb begin
		sign = src[63];
		bexp = src[62:52];
		frac = src[51:0];
		fwe  = {1'b0, fmt.fw};
		exp_ones = (64'd1 << fmt.ew) - 64'd1;
		inf_mag  = exp_ones << fmt.fw;
		mag = '0;
		inx = 1'b0;
		ovf = 1'b0;
		q = '0;
		g = 1'b0;
		rest = 1'b0;
		rest_mask = '0;
		m = (bexp != 11'd0) ? {1'b1, frac} : {1'b0, frac};
		e = (bexp != 11'd0) ? $signed({3'd0, bexp}) - 14'sd1023 : -14'sd1022;
		// Leading one position.
		p = '0;
		for (int i = 0; i < 53; i++) begin
			if (m[i]) p = 6'(i);
		end
		x = e - 14'sd52 + $signed({8'd0, p});
		bias = $signed(14'((14'd1 << (fmt.ew - 4'd1)) - 14'd1));
		emin = 14'sd1 - bias;
		normal = (x >= emin);
		base = normal ? x : emin;
		shift = base - $signed({7'd0, fwe}) - (e - 14'sd52);
		mext = {11'd0, m};
		if (bexp == 11'h7FF) begin
			mag = (frac != 52'd0) ? (inf_mag | (64'd1 << (fmt.fw - 6'd1))) : inf_mag;
		end else if (m != 53'd0) begin
			if (x > bias) begin
				mag = inf_mag;
				inx = 1'b1;
				ovf = 1'b1;
			end else begin
				if (shift <= 14'sd0) begin
					q = mext << 6'(-shift);
				end else if (shift > 14'sd60) begin
					q = '0;
					inx = 1'b1;
				end else begin
					g = mext[6'(shift - 14'sd1)];
					rest_mask = (64'd1 << 6'(shift - 14'sd1)) - 64'd1;
					rest = |(mext & rest_mask);
					q = mext >> 6'(shift);
					inx = g | rest;
					if (g && (rest || q[0])) q = q + 64'd1;
				end
				if (normal) mag = (64'(x + bias - 14'sd1) << fmt.fw) + q;
				else mag = q;
				if ((mag >> fmt.fw) >= exp_ones) begin
					mag = inf_mag;
					ovf = 1'b1;
					inx = 1'b1;
				end
			end
		end
		res.packed_value = ({63'd0, sign} << (fmt.ew + 7'(fmt.fw))) | mag;
		res.inexact = inx;
		res.overflowed = ovf;
	end
endmodule

// ----- rtl/double_to_minifloat_rne.sv -----
// Top level: input register, converter, result register.
// Converts an IEEE double to a float with configurable exponent (2..11) and fraction
// (1..52) widths, rounding to nearest even. An item is accepted every cycle unless the
// result stalls; the input register feeds a single combinational conversion whose output
// goes to the result register. A stalled result holds it and a full input register, so
// at most two items are in flight. The user must write configuration through APB
// (exponent_width at 0x0, fraction_width at 0x4) while the block is idle; not enforced.
module double_to_minifloat_rne (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [dtm_pkg::AddrW-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	dtm_src_if.sink                   src,
	dtm_res_if.source                 res
);
	dtm_pkg::fmt_t    fmt;
	dtm_pkg::result_t conv;
	logic [dtm_pkg::SrcW-1:0] src_s1;
	logic valid_s1, valid_s2;
	dtm_pkg::result_t res_s2;
	logic adv_s2, ready_s1;

	dtm_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .fmt
	);

	// Stage 2 takes when empty or drained.
	assign adv_s2 = !valid_s2 || res.ready;
	assign ready_s1 = !valid_s1 || adv_s2;
	assign src.ready = ready_s1;

	// Hold the input item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (ready_s1) valid_s1 <= src.valid;
	end
	always_ff @(posedge clk) begin
		if (ready_s1 && src.valid) src_s1 <= src.source_bits;
	end

	dtm_convert u_conv (.src(src_s1), .fmt, .res(conv));

	// Register the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else if (adv_s2) valid_s2 <= valid_s1;
	end
	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) res_s2 <= conv;
	end

	assign res.valid = valid_s2;
	assign res.packed_value = res_s2.packed_value;
	assign res.inexact = res_s2.inexact;
	assign res.overflowed = res_s2.overflowed;
endmodule

// ----- rtl/dtm_checker.sv -----
// Port-level checks for the converter, bound to the top level.
module dtm_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_inexact,
	input logic out_overflowed
);
	// Overflow always reports inexact.
	a_ovf_inx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_overflowed |-> out_inexact) else $error("overflow without inexact");

	// Stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");

	// Input ready whenever the output is drained.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready) else $error("input stalled with free output");

	// An accepted item reaches the output when unstalled.
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready ##1 out_ready ##1 out_ready |-> out_valid || $past(out_valid))
		else $error("item lost");
endmodule

bind double_to_minifloat_rne dtm_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(src.valid), .in_ready(src.ready),
	.out_valid(res.valid), .out_ready(res.ready), .out_inexact(res.inexact),
	.out_overflowed(res.overflowed)
);
